/* rtl/pol_pkg.sv */
// Package for the positional ordered list: sizes, request/response codes,
// transaction payload structs and the per-cell command struct.
// No dependencies.
package pol_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [7:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [7:0]         found_position;
		logic signed [31:0] read_value;
		logic [7:0]         list_length;
	} rsp_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		logic               ins;    // insert commits this cycle
		logic               del;    // delete commits this cycle
		logic [7:0]         pos0;   // zero-based target position
		logic [CNT_W-1:0]   count;  // entries held before the request
		logic signed [31:0] value;  // insert value / search key
	} cell_cmd_t;

endpackage

/* rtl/pol_cell.sv */
// One list cell: holds a single entry, shifts with its neighbors on
// insert/delete, compares against the search key, drives its entry on read.
// Depends on pol_pkg.
module pol_cell (
	input  logic                     clk,
	input  pol_pkg::cell_cmd_t       cmd,
	input  logic [pol_pkg::IDX_W-1:0] idx,
	input  logic signed [31:0]       prev_data,
	input  logic signed [31:0]       next_data,
	output logic signed [31:0]       data,
	output logic                     hit,
	output logic signed [31:0]       rd_data
);
	import pol_pkg::*;

	logic signed [31:0] data_q;
	logic [8:0]         idx9;
	logic [8:0]         pos9;
	logic               at_pos;
	logic               past_pos;
	logic               in_list;

	assign idx9     = 9'(idx);
	assign pos9     = {1'b0, cmd.pos0};
	assign at_pos   = (idx9 == pos9);
	assign past_pos = (idx9 > pos9);
	assign in_list  = (idx9 < 9'(cmd.count));

	// entries at/after the target slide one place; no reset on payload
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_pos) begin
				data_q <= cmd.value;
			end else if (past_pos) begin
				data_q <= prev_data;
			end
		end else if (cmd.del && (at_pos || past_pos)) begin
			data_q <= next_data;
		end
	end

	assign data    = data_q;
	assign hit     = in_list && (data_q == cmd.value);
	assign rd_data = at_pos ? data_q : 32'sd0;

endmodule

/* rtl/positional_ordered_list.sv */
// Top level of the positional ordered list: request decode, chain of
// pol_cell instances, entry count and the registered response.
// Depends on pol_pkg and pol_cell.
//
//  channel | direction | payload       | handshake
//  --------+-----------+---------------+----------------------
//  req     | in        | pol_pkg::req_t | req_valid / req_ready
//  rsp     | out       | pol_pkg::rsp_t | rsp_valid / rsp_ready
//
// For every request, all cells compare their index against the
// position (or their entry against the key) and shift in the same edge.
// The response lands in an output register the cycle after acceptance.
// A new request is taken while that register is empty or being drained,
// so one transaction per cycle is sustained when rsp_ready stays high.
// Reset empties the list (count to zero); cell contents are left as is.
module positional_ordered_list (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pol_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pol_pkg::rsp_t rsp
);
	import pol_pkg::*;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_nxt;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               rsp_nxt;
	logic               accept;

	logic [8:0]         pos9;
	logic [8:0]         n9;
	logic               ins_bad;
	logic               range_bad;
	logic               is_full;

	cell_cmd_t          cmd;
	logic signed [31:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_hit;
	logic signed [31:0] cell_rd   [CAPACITY];
	logic signed [31:0] rd_or;
	logic [7:0]         first_hit;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// position checks, done in 9 bits so length+1 never wraps
	assign pos9      = {1'b0, req.position};
	assign n9        = 9'(count_q);
	assign ins_bad   = (req.position == 8'd0) || (pos9 > n9 + 9'd1);
	assign range_bad = (req.position == 8'd0) || (pos9 > n9);
	assign is_full   = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		cmd.ins   = accept && (req.op == OP_INSERT) && !ins_bad && !is_full;
		cmd.del   = accept && (req.op == OP_DELETE) && !range_bad;
		cmd.pos0  = req.position - 8'd1;
		cmd.count = count_q;
		cmd.value = req.value;
	end

	// the cell chain: each cell sees its left and right neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_d;
		logic signed [31:0] next_d;

		// end cells: never shifted from outside, tie to something harmless
		if (i == 0) begin : g_first
			assign prev_d = req.value;
		end else begin : g_mid_l
			assign prev_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_mid_r
			assign next_d = cell_data[i+1];
		end

		pol_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.idx       (IDX_W'(i)),
			.prev_data (prev_d),
			.next_data (next_d),
			.data      (cell_data[i]),
			.hit       (cell_hit[i]),
			.rd_data   (cell_rd[i])
		);
	end

	// lowest matching index wins; only one cell drives a nonzero read
	always_comb begin
		first_hit = 8'd0;
		rd_or     = 32'sd0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_hit[i]) begin
				first_hit = 8'(i + 1);
			end
		end
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
	end

	always_comb begin
		count_nxt              = count_q;
		rsp_nxt.status         = ST_OK;
		rsp_nxt.found_position = 8'd0;
		rsp_nxt.read_value     = 32'sd0;
		unique case (req.op)
			OP_INSERT: begin
				if (ins_bad) begin
					rsp_nxt.status = ST_BADPOS;
				end else if (is_full) begin
					rsp_nxt.status = ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			OP_DELETE: begin
				if (range_bad) begin
					rsp_nxt.status = ST_BADPOS;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			OP_FIND: begin
				if (first_hit == 8'd0) begin
					rsp_nxt.status = ST_NOTFOUND;
				end else begin
					rsp_nxt.found_position = first_hit;
				end
			end
			OP_READ: begin
				if (range_bad) begin
					rsp_nxt.status = ST_BADPOS;
				end else begin
					rsp_nxt.read_value = rd_or;
				end
			end
			default: begin
				rsp_nxt.status = ST_BADPOS;
			end
		endcase
		rsp_nxt.list_length = 8'(count_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_len_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.list_length == 8'(count_q)))
		else $error("reported length differs from entry count");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_q.found_position != 8'd0)) |-> (rsp_q.status == ST_OK))
		else $error("find position reported with failing status");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without a transaction");
`endif

endmodule
